// ===== rtl/core/pgalloc_pkg.sv =====
package pgalloc_pkg;

  // Sizing of the stores
  localparam int PAGE_COUNT = 4096;
  localparam int REF_BITS   = 16;
  localparam int PAGE_W     = $clog2(PAGE_COUNT);
  localparam int FCNT_W     = PAGE_W + 1;

  // Fixed field widths of the channels
  localparam int KIND_W       = 3;
  localparam int PAGE_NUM_W   = 13;
  localparam int STATUS_W     = 3;
  localparam int ALLOC_PAGE_W = 12;
  localparam int REF_VALUE_W  = 16;
  localparam int FREE_PAGES_W = 13;
  localparam int CFG_W        = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_INC   = 3'd2,
    KIND_DEC   = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_BAD_FREE  = 3'd2,
    ST_STILL_REF = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } fsm_t;

  // Count memory port
  typedef struct packed {
    logic                we;
    logic [PAGE_W-1:0]   waddr;
    logic [REF_BITS-1:0] wdata;
    logic                re;
    logic [PAGE_W-1:0]   raddr;
  } ref_port_t;

  // Free stack memory port
  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [PAGE_W-1:0] wdata;
    logic              re;
    logic [PAGE_W-1:0] raddr;
  } stk_port_t;

endpackage

// ===== rtl/core/pgalloc_if.sv =====
interface pgalloc_in_if;
  import pgalloc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [PAGE_NUM_W-1:0] page_number;
  modport source (output valid, kind, page_number, input ready);
  modport sink (input valid, kind, page_number, output ready);
endinterface

interface pgalloc_out_if;
  import pgalloc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [ALLOC_PAGE_W-1:0] alloc_page;
  logic [REF_VALUE_W-1:0]  ref_value;
  logic [FREE_PAGES_W-1:0] free_pages;
  modport source (output valid, status, alloc_page, ref_value, free_pages, input ready);
  modport sink (input valid, status, alloc_page, ref_value, free_pages, output ready);
endinterface

interface pgalloc_cfg_if;
  import pgalloc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/pgalloc_ram.sv =====
module pgalloc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pgalloc_ctrl.sv =====
module pgalloc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pgalloc_pkg::CFG_W-1:0] first_usable_page,
  pgalloc_in_if.sink                   in_ch,
  pgalloc_out_if.source                out_ch,
  output pgalloc_pkg::ref_port_t       ref_port,
  input  logic [pgalloc_pkg::REF_BITS-1:0] ref_rdata,
  output pgalloc_pkg::stk_port_t       stk_port,
  input  logic [pgalloc_pkg::PAGE_W-1:0] stk_rdata
);
  import pgalloc_pkg::*;

  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [FCNT_W-1:0]   FCNT_FULL = FCNT_W'(PAGE_COUNT);
  localparam logic [PAGE_W-1:0]   CLR_LAST = PAGE_W'(PAGE_COUNT - 1);

  fsm_t                    state_r, state_nxt;
  logic [PAGE_W-1:0]       clr_r, clr_nxt;
  logic [FCNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [KIND_W-1:0]       req_kind_r;
  logic [PAGE_NUM_W-1:0]   req_page_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [ALLOC_PAGE_W-1:0] out_alloc_r, out_alloc_nxt;
  logic [REF_VALUE_W-1:0]  out_ref_r, out_ref_nxt;
  logic [FREE_PAGES_W-1:0] out_free_r, out_free_nxt;

  logic                    acc;
  logic                    go;
  logic                    in_range;
  logic [PAGE_W-1:0]       req_idx;
  logic [REF_BITS-1:0]     cnt_dec;
  logic [REF_BITS-1:0]     cnt_inc;
  logic                    ex_ref_we;
  logic [PAGE_W-1:0]       ex_ref_addr;
  logic [REF_BITS-1:0]     ex_ref_data;
  logic                    ex_push;

  assign acc      = in_ch.valid && in_ch.ready;
  assign go       = !out_valid_r || out_ch.ready;
  assign in_range = 32'(req_page_r) < 32'(PAGE_COUNT);
  assign req_idx  = PAGE_W'(req_page_r);
  assign cnt_dec  = (ref_rdata != '0) ? ref_rdata - 1'b1 : ref_rdata;
  assign cnt_inc  = (ref_rdata != REF_MAX) ? ref_rdata + 1'b1 : ref_rdata;

  // Next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // FSM outputs: handshake and memory ports
  always_comb begin
    in_ch.ready    = 1'b0;
    ref_port.we    = 1'b0;
    ref_port.waddr = ex_ref_addr;
    ref_port.wdata = ex_ref_data;
    ref_port.re    = 1'b0;
    ref_port.raddr = PAGE_W'(in_ch.page_number);
    stk_port.we    = 1'b0;
    stk_port.waddr = PAGE_W'(fcnt_r);
    stk_port.wdata = req_idx;
    stk_port.re    = 1'b0;
    stk_port.raddr = PAGE_W'(fcnt_r - FCNT_W'(1));
    case (state_r)
      S_CLEAR: begin
        ref_port.we    = 1'b1;
        ref_port.waddr = clr_r;
        ref_port.wdata = '0;
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        // reads launch on the accepting edge
        ref_port.re = in_ch.valid;
        stk_port.re = in_ch.valid;
      end
      S_EXEC: begin
        ref_port.we = go && ex_ref_we;
        stk_port.we = go && ex_push;
      end
      default: ;
    endcase
  end

  // Request execution on the read data
  always_comb begin
    ex_ref_we      = 1'b0;
    ex_ref_addr    = req_idx;
    ex_ref_data    = '0;
    ex_push        = 1'b0;
    fcnt_nxt       = fcnt_r;
    out_status_nxt = ST_OK;
    out_alloc_nxt  = '0;
    out_ref_nxt    = '0;
    case (kind_t'(req_kind_r))
      KIND_ALLOC: begin
        if (fcnt_r == '0) begin
          out_status_nxt = ST_OOM;
        end else begin
          fcnt_nxt      = fcnt_r - 1'b1;
          ex_ref_we     = 1'b1;
          ex_ref_addr   = stk_rdata;
          ex_ref_data   = REF_BITS'(1);
          out_alloc_nxt = ALLOC_PAGE_W'(stk_rdata);
          out_ref_nxt   = REF_VALUE_W'(1);
        end
      end
      KIND_FREE: begin
        if (req_page_r < first_usable_page || !in_range) begin
          out_status_nxt = ST_BAD_FREE;
        end else begin
          ex_ref_we   = 1'b1;
          ex_ref_data = cnt_dec;
          out_ref_nxt = REF_VALUE_W'(cnt_dec);
          if (cnt_dec != '0) begin
            out_status_nxt = ST_STILL_REF;
          end else if (fcnt_r == FCNT_FULL) begin
            out_status_nxt = ST_FULL;
          end else begin
            ex_push  = 1'b1;
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end
      end
      KIND_INC: begin
        if (in_range) begin
          ex_ref_we   = 1'b1;
          ex_ref_data = cnt_inc;
          out_ref_nxt = REF_VALUE_W'(cnt_inc);
        end
      end
      KIND_DEC: begin
        if (in_range) begin
          ex_ref_we   = 1'b1;
          ex_ref_data = cnt_dec;
          out_ref_nxt = REF_VALUE_W'(cnt_dec);
        end
      end
      KIND_READ: begin
        if (in_range) begin
          out_ref_nxt = REF_VALUE_W'(ref_rdata);
        end
      end
      default: ;
    endcase
    out_free_nxt = FREE_PAGES_W'(fcnt_nxt);
  end

  // Result slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_EXEC && go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.alloc_page = out_alloc_r;
  assign out_ch.ref_value  = out_ref_r;
  assign out_ch.free_pages = out_free_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EXEC && go) begin
        fcnt_r <= fcnt_nxt;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      req_kind_r <= in_ch.kind;
      req_page_r <= in_ch.page_number;
    end
    if (state_r == S_EXEC && go) begin
      out_status_r <= out_status_nxt;
      out_alloc_r  <= out_alloc_nxt;
      out_ref_r    <= out_ref_nxt;
      out_free_r   <= out_free_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_FULL)
    else $error("free count above page count");

  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == S_EXEC)
    else $error("accepted request not executed next cycle");

  a_fcnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_EXEC |=> $stable(fcnt_r))
    else $error("free count moved outside execute");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("result raised without an executed request");
`endif

endmodule

// ===== rtl/core/page_allocator_with_refcount.sv =====
// Page allocator with per-page reference counts. Each request (allocate, free,
// increment, decrement or read reference) returns exactly one result carrying a
// status, the allocated page, the page's count after the operation and the number
// of pages on the free stack. The free stack starts empty: software fills it by
// freeing pages. After reset the count memory is cleared one entry per cycle with
// in_ch.ready low; configuration writes are taken throughout. A request's accept
// cycle reads the count memory and the top of the free stack; the execute state
// then writes any new count back, pushes a freed page, loads the result register
// and blocks new requests until it ends. A waiting result does not block the next
// request being accepted; only the following write-back waits for the result slot.
module page_allocator_with_refcount (
  input  logic           clk,
  input  logic           rst_n,
  pgalloc_in_if.sink     in_ch,
  pgalloc_out_if.source  out_ch,
  pgalloc_cfg_if.sink    cfg_ch
);
  import pgalloc_pkg::*;

  logic [CFG_W-1:0]    first_usable_r;
  ref_port_t           ref_port;
  stk_port_t           stk_port;
  logic [REF_BITS-1:0] ref_rdata;
  logic [PAGE_W-1:0]   stk_rdata;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_usable_r <= '0;
    end else if (cfg_ch.valid) begin
      first_usable_r <= cfg_ch.data;
    end
  end

  // Reference count memory
  pgalloc_ram #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (REF_BITS)
  ) u_ref_mem (
    .clk   (clk),
    .we    (ref_port.we),
    .waddr (ref_port.waddr),
    .wdata (ref_port.wdata),
    .re    (ref_port.re),
    .raddr (ref_port.raddr),
    .rdata (ref_rdata)
  );

  // Free page stack memory
  pgalloc_ram #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (PAGE_W)
  ) u_stk_mem (
    .clk   (clk),
    .we    (stk_port.we),
    .waddr (stk_port.waddr),
    .wdata (stk_port.wdata),
    .re    (stk_port.re),
    .raddr (stk_port.raddr),
    .rdata (stk_rdata)
  );

  pgalloc_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .first_usable_page (first_usable_r),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .ref_port          (ref_port),
    .ref_rdata         (ref_rdata),
    .stk_port          (stk_port),
    .stk_rdata         (stk_rdata)
  );

endmodule

// ===== tb/sv/page_allocator_with_refcount_tb.sv =====
`timescale 1ns / 100ps

module page_allocator_with_refcount_tb;
  import pgalloc_pkg::*;

  // Unused request kinds, taken as no-ops
  localparam logic [KIND_W-1:0] KIND_NOP_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NOP_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOP_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_REQUESTS = 240;
  localparam int FILL_PAGES     = 16;
  localparam int LAST_PAGE      = PAGE_COUNT - 1;

  typedef struct packed {
    status_t                 status;
    logic [ALLOC_PAGE_W-1:0] alloc_page;
    logic [REF_VALUE_W-1:0]  ref_value;
    logic [FREE_PAGES_W-1:0] free_pages;
  } page_result_t;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [PAGE_NUM_W-1:0] page;
    bit                    typed;
    page_result_t          result;
  } directed_row_t;

  localparam page_result_t NO_RESULT      = '0;
  localparam page_result_t OOM_EMPTY      = '{ST_OOM, 12'd0, 16'd0, 13'd0};
  localparam page_result_t BAD_FREE_EMPTY = '{ST_BAD_FREE, 12'd0, 16'd0, 13'd0};
  localparam page_result_t NOOP_EMPTY     = '{ST_OK, 12'd0, 16'd0, 13'd0};

  // Directed requests; typed rows carry their result, the rest use the predictor
  directed_row_t directed_rows [23] = '{
    '{KIND_ALLOC, 13'd0,    1'b1, OOM_EMPTY},
    '{KIND_READ,  13'd8191, 1'b1, NOOP_EMPTY},
    '{KIND_FREE,  13'd8191, 1'b1, BAD_FREE_EMPTY},
    '{KIND_FREE,  13'd4096, 1'b1, BAD_FREE_EMPTY},
    '{KIND_INC,   13'd4096, 1'b1, NOOP_EMPTY},
    '{KIND_DEC,   13'd8191, 1'b1, NOOP_EMPTY},
    '{KIND_NOP_5, 13'd0,    1'b1, NOOP_EMPTY},
    '{KIND_NOP_6, 13'd8191, 1'b1, NOOP_EMPTY},
    '{KIND_NOP_7, 13'd4095, 1'b1, NOOP_EMPTY},
    '{KIND_FREE,  13'd0,    1'b1, '{ST_OK, 12'd0, 16'd0, 13'd1}},
    '{KIND_FREE,  13'd4095, 1'b1, '{ST_OK, 12'd0, 16'd0, 13'd2}},
    '{KIND_ALLOC, 13'd8191, 1'b0, NO_RESULT},
    '{KIND_INC,   13'd4095, 1'b0, NO_RESULT},
    '{KIND_INC,   13'd4095, 1'b0, NO_RESULT},
    '{KIND_FREE,  13'd4095, 1'b0, NO_RESULT},
    '{KIND_DEC,   13'd4095, 1'b0, NO_RESULT},
    '{KIND_DEC,   13'd4095, 1'b0, NO_RESULT},
    '{KIND_DEC,   13'd4095, 1'b0, NO_RESULT},
    '{KIND_READ,  13'd0,    1'b0, NO_RESULT},
    '{KIND_FREE,  13'd0,    1'b0, NO_RESULT},
    '{KIND_ALLOC, 13'd4095, 1'b0, NO_RESULT},
    '{KIND_ALLOC, 13'd0,    1'b0, NO_RESULT},
    '{KIND_ALLOC, 13'd0,    1'b1, OOM_EMPTY}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pgalloc_in_if  in_ch ();
  pgalloc_out_if out_ch ();
  pgalloc_cfg_if cfg_ch ();

  page_allocator_with_refcount dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the allocator state
  logic [REF_BITS-1:0]     ref_counts_exp [PAGE_COUNT] = '{default: '0};
  logic [PAGE_W-1:0]       free_stack_exp [PAGE_COUNT] = '{default: '0};
  logic [FCNT_W-1:0]       free_count_exp = '0;
  logic [CFG_W-1:0]        first_usable_exp = '0;

  page_result_t pending_results [$];

  // Typed expectation riding along with the request payload
  logic         req_typed = 1'b0;
  page_result_t req_expect = '0;

  logic sink_ready = 1'b0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   requests_issued = 0;
  int   requests_accepted = 0;
  int   results_checked = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  assign out_ch.ready = sink_ready;

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the mirror, return the result it should produce
  function automatic page_result_t predict_page_op(input logic [KIND_W-1:0] kind,
                                                   input logic [PAGE_NUM_W-1:0] page);
    page_result_t          res;
    logic                  in_range;
    logic [PAGE_W-1:0]     idx;
    logic [REF_BITS-1:0]   cnt;
    res      = NOOP_EMPTY;
    in_range = (page < PAGE_COUNT);
    idx      = page[PAGE_W-1:0];
    case (kind_t'(kind))
      KIND_ALLOC: begin
        if (free_count_exp == 0) begin
          res.status = ST_OOM;
        end else begin
          free_count_exp = free_count_exp - 1'b1;
          idx = free_stack_exp[free_count_exp[PAGE_W-1:0]];
          ref_counts_exp[idx] = REF_BITS'(1);
          res.alloc_page = idx;
          res.ref_value  = REF_VALUE_W'(1);
        end
      end
      KIND_FREE: begin
        if (page < first_usable_exp || !in_range) begin
          res.status = ST_BAD_FREE;
        end else begin
          cnt = ref_counts_exp[idx];
          if (cnt != 0) cnt = cnt - 1'b1;
          ref_counts_exp[idx] = cnt;
          res.ref_value = cnt;
          if (cnt != 0) begin
            res.status = ST_STILL_REF;
          end else if (free_count_exp >= PAGE_COUNT) begin
            res.status = ST_FULL;
          end else begin
            free_stack_exp[free_count_exp[PAGE_W-1:0]] = idx;
            free_count_exp = free_count_exp + 1'b1;
          end
        end
      end
      KIND_INC: begin
        if (in_range) begin
          if (ref_counts_exp[idx] != '1) ref_counts_exp[idx] = ref_counts_exp[idx] + 1'b1;
          res.ref_value = ref_counts_exp[idx];
        end
      end
      KIND_DEC: begin
        if (in_range) begin
          if (ref_counts_exp[idx] != 0) ref_counts_exp[idx] = ref_counts_exp[idx] - 1'b1;
          res.ref_value = ref_counts_exp[idx];
        end
      end
      KIND_READ: begin
        if (in_range) res.ref_value = ref_counts_exp[idx];
      end
      default: ;
    endcase
    res.free_pages = free_count_exp;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Page near the first usable page, so requests keep hitting the same few pages
  function automatic logic [PAGE_NUM_W-1:0] pool_page(input logic [CFG_W-1:0] first_usable);
    logic [PAGE_NUM_W-1:0] base;
    base = (first_usable < 8) ? '0 : first_usable - 13'd8;
    if (base > PAGE_COUNT - 32) base = PAGE_NUM_W'(PAGE_COUNT - 32);
    return base + PAGE_NUM_W'($urandom_range(0, 31));
  endfunction

  // Scoreboard: results first, so a request never matches its own edge
  always @(posedge clk) begin : scoreboard
    page_result_t got;
    page_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{status_t'(out_ch.status), out_ch.alloc_page, out_ch.ref_value,
                out_ch.free_pages};
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d alloc_page %0d ref_value %0d free_pages %0d",
                 got.status, got.alloc_page, got.ref_value, got.free_pages);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("alloc_page", 32'(want.alloc_page), 32'(got.alloc_page));
          check_field("ref_value", 32'(want.ref_value), 32'(got.ref_value));
          check_field("free_pages", 32'(want.free_pages), 32'(got.free_pages));
          results_checked++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) first_usable_exp = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        want = predict_page_op(in_ch.kind, in_ch.page_number);
        if (req_typed) want = req_expect;
        pending_results.push_back(want);
        requests_accepted++;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("page_allocator_with_refcount_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and hold it until accepted; valid stays high on return
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [PAGE_NUM_W-1:0] page,
                              input bit typed = 1'b0,
                              input page_result_t expect_res = '0);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.page_number <= page;
    req_typed         <= typed;
    req_expect        <= expect_res;
    requests_issued++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering requests until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_first_usable(input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int                    phase;
    int                    phase_start;
    int                    n;
    int                    roll;
    logic [PAGE_NUM_W-1:0] p;
    logic [CFG_W-1:0]      first_usable;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_ALLOC;
    in_ch.page_number <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    src_idle_pct   = 20;
    sink_stall_pct = 52;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    first_usable = '0;
    write_first_usable(first_usable);

    // Directed table
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].kind, directed_rows[r].page, directed_rows[r].typed,
                   directed_rows[r].result);
    end
    wait_drained();

    // Push a few pages, then drain the stack past empty
    for (int j = 0; j < FILL_PAGES; j++) begin
      send_request(KIND_FREE, PAGE_NUM_W'(j));
    end
    for (int j = 0; j < FILL_PAGES + 5; j++) begin
      send_request(KIND_ALLOC, PAGE_NUM_W'($urandom));
    end
    wait_drained();

    // Random phases, one first_usable_page setting each
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       first_usable = CFG_W'($urandom_range(2, PAGE_COUNT - 2));
        1:       first_usable = CFG_W'(PAGE_COUNT);
        2:       first_usable = CFG_W'(1);
        3:       first_usable = CFG_W'(LAST_PAGE);
        default: first_usable = '0;
      endcase
      if (phase == 2) begin
        src_idle_pct   = 52;
        sink_stall_pct = 20;
      end
      if (phase == 4) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      write_first_usable(first_usable);
      phase_start = requests_issued;
      while (requests_issued - phase_start < PHASE_REQUESTS) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          // hold off until the pipeline is empty
          wait_drained();
        end else if (roll < 72) begin
          // page lifecycle: free, allocate, take references, read the count, drop them
          p = pool_page(first_usable);
          send_request(KIND_FREE, p);
          send_request(KIND_ALLOC, PAGE_NUM_W'($urandom));
          n = $urandom_range(0, 3);
          repeat (n) send_request(KIND_INC, p);
          send_request(KIND_READ, p);
          repeat ($urandom_range(1, n + 2)) send_request(KIND_FREE, p);
          if ($urandom_range(0, 1) == 1) send_request(KIND_DEC, p);
        end else begin
          // noise: any kind, any page number
          case ($urandom_range(0, 2))
            0:       p = pool_page(first_usable);
            1:       p = PAGE_NUM_W'($urandom_range(0, LAST_PAGE));
            default: p = PAGE_NUM_W'($urandom);
          endcase
          send_request(KIND_W'($urandom_range(0, 7)), p);
        end
      end
      wait_drained();
    end
    repeat (8) @(posedge clk);

    $display("%0d requests accepted, %0d results checked: empty free stack, bad frees,",
             requests_accepted, results_checked);
    $display("page lifecycles, several first_usable_page settings, three idle patterns");
    if (mismatches == 0) begin
      $display("page_allocator_with_refcount_tb: done, clean");
    end else begin
      $display("page_allocator_with_refcount_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pgalloc_pkg.sv
rtl/core/pgalloc_if.sv
rtl/core/pgalloc_ram.sv
rtl/core/pgalloc_ctrl.sv
rtl/core/page_allocator_with_refcount.sv
tb/sv/page_allocator_with_refcount_tb.sv
